// File: sv/gceh_pkg.sv
// Shared types, sizes and helper functions for the gated channel energy histogram.
// Depends on nothing; the top level imports it, while gceh_ram is generic and does not.
package gceh_pkg;

    localparam int CHANNELS = 32;
    localparam int BINS     = 32768;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int BIN_W    = $clog2(BINS);
    localparam int ADDR_W   = CH_W + BIN_W;
    localparam int COUNT_W  = 32;
    localparam int IN_W     = 88;

    typedef enum logic [2:0] {
        ST_COUNTED = 3'd0,
        ST_NOHIT   = 3'd1,
        ST_TYPE    = 3'd2,
        ST_CHI     = 3'd3,
        ST_RANGE   = 3'd4,
        ST_READ    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_TYPE_MIN = 2'd0,
        REG_TYPE_MAX = 2'd1,
        REG_CHI_MIN  = 2'd2,
        REG_CHI_MAX  = 2'd3
    } cfg_reg_t;

    // Channel number as the upper part of a histogram address.
    function automatic logic [CH_W-1:0] ch_index(input logic [4:0] ch);
        logic [6:0] ext;
        ext = {2'b00, ch};
        return ext[CH_W-1:0];
    endfunction

    // Read bin number as the lower part of a histogram address.
    function automatic logic [BIN_W-1:0] bin_index(input logic [15:0] b);
        return b[BIN_W-1:0];
    endfunction

endpackage

// File: sv/gceh_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Generic; used by the histogram top level for the bin counters.
module gceh_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 20
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/gated_channel_energy_histogram_top.sv
// Top level of the gated channel energy histogram: record gating, rounding,
// bin counter read-modify-write. Depends on gceh_pkg and gceh_ram.
// Each item passes the states S_CHECK, S_DECIDE, S_MEM and S_DONE (a rejected record
// skips S_MEM); one item is in flight at a time, so a new item is not taken before
// the last is through the read-modify-write of the counter RAM. A new item is taken
// while the previous result still waits on the output. After reset a clearing pass
// writes zero to all 2**ADDR_W counters before the first item is taken.
module gated_channel_energy_histogram_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // channel[4:0], hit[5], fit_type[13:6], chisq[37:14], ndf[45:38],
    // energy[65:46], read_bin[80:66], zero[87:81]
    input  logic [gceh_pkg::IN_W-1:0]      s_tdata,
    // op[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // count[31:0]
    output logic [gceh_pkg::COUNT_W-1:0]   m_tdata,
    // status[2:0]
    output logic [2:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [23:0]                    cfg_data
);
    import gceh_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_DECIDE = 6'b001000,
        S_MEM    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  type_min_reg, type_max_reg;
    logic [23:0] chi_min_reg, chi_max_reg;

    // Captured item.
    logic        op_reg;
    logic [4:0]  channel_reg;
    logic        hit_reg;
    logic [7:0]  fit_type_reg;
    logic [23:0] chisq_reg;
    logic [7:0]  ndf_reg;
    logic [19:0] energy_reg;
    logic [14:0] read_bin_reg;

    // Check stage results.
    logic [31:0] pmin_reg, pmax_reg;
    logic [16:0] bin_reg;
    logic        nohit_reg, type_fail_reg, rd_ok_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic               counted_reg;
    status_t            status_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [COUNT_W-1:0] ram_wr_data, ram_rd_data, new_count;

    logic signed [15:0] whole;
    logic [3:0]         frac;
    logic               round_up;
    logic [16:0]        bin_round;
    logic               chi_fail, range_fail, out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_count_reg;
    assign m_tuser   = out_status_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Half-to-even rounding of the Q15.4 energy.
    assign whole     = energy_reg[19:4];
    assign frac      = energy_reg[3:0];
    assign round_up  = (frac > 4'd8) || ((frac == 4'd8) && whole[0]);
    assign bin_round = {whole[15], whole} + {16'd0, round_up};

    assign chi_fail   = (ndf_reg == 8'd0) || ({8'd0, chisq_reg} < pmin_reg)
                        || ({8'd0, chisq_reg} > pmax_reg);
    assign range_fail = bin_reg[16] || ({16'd0, bin_reg[15:0]} >= BINS);

    assign new_count  = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_cnt_reg == '1) state_next = S_IDLE;
            S_IDLE:   if (s_tvalid) state_next = S_CHECK;
            S_CHECK:  state_next = S_DECIDE;
            S_DECIDE: state_next = ram_rd_en ? S_MEM : S_DONE;
            S_MEM:    state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        ram_rd_en = 1'b0;
        if (state_reg == S_DECIDE)
        begin
            if (op_reg)
            begin
                ram_rd_en = rd_ok_reg;
            end
            else
            begin
                ram_rd_en = !nohit_reg && !type_fail_reg && !chi_fail && !range_fail;
            end
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = (state_reg == S_MEM) && counted_reg;
            ram_wr_addr = addr_reg;
            ram_wr_data = new_count;
        end
    end

    gceh_ram #(
        .DATA_W (COUNT_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            type_min_reg  <= 8'd0;
            type_max_reg  <= 8'd255;
            chi_min_reg   <= 24'd0;
            chi_max_reg   <= 24'hFFFFFF;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TYPE_MIN: type_min_reg <= cfg_data[7:0];
                    REG_TYPE_MAX: type_max_reg <= cfg_data[7:0];
                    REG_CHI_MIN:  chi_min_reg  <= cfg_data;
                    REG_CHI_MAX:  chi_max_reg  <= cfg_data;
                    default:      ;
                endcase
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg       <= s_tuser;
            channel_reg  <= s_tdata[4:0];
            hit_reg      <= s_tdata[5];
            fit_type_reg <= s_tdata[13:6];
            chisq_reg    <= s_tdata[37:14];
            ndf_reg      <= s_tdata[45:38];
            energy_reg   <= s_tdata[65:46];
            read_bin_reg <= s_tdata[80:66];
        end

        if (state_reg == S_CHECK)
        begin
            pmin_reg      <= chi_min_reg * ndf_reg;
            pmax_reg      <= chi_max_reg * ndf_reg;
            bin_reg       <= bin_round;
            nohit_reg     <= !hit_reg || (channel_reg == 5'd0)
                             || ({27'd0, channel_reg} >= CHANNELS);
            type_fail_reg <= (fit_type_reg < type_min_reg) || (fit_type_reg > type_max_reg);
            rd_ok_reg     <= ({27'd0, channel_reg} < CHANNELS)
                             && ({17'd0, read_bin_reg} < BINS);
            if (op_reg)
            begin
                addr_reg <= {ch_index(channel_reg), bin_index({1'b0, read_bin_reg})};
            end
            else
            begin
                addr_reg <= {ch_index(channel_reg), bin_index(bin_round[15:0])};
            end
        end

        if (state_reg == S_DECIDE)
        begin
            counted_reg   <= !op_reg && ram_rd_en;
            res_count_reg <= '0;
            if (op_reg)
            begin
                status_reg <= ST_READ;
            end
            else if (nohit_reg)
            begin
                status_reg <= ST_NOHIT;
            end
            else if (type_fail_reg)
            begin
                status_reg <= ST_TYPE;
            end
            else if (chi_fail)
            begin
                status_reg <= ST_CHI;
            end
            else if (range_fail)
            begin
                status_reg <= ST_RANGE;
            end
            else
            begin
                status_reg <= ST_COUNTED;
            end
        end

        if (state_reg == S_MEM)
        begin
            res_count_reg <= counted_reg ? new_count : ram_rd_data;
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= res_count_reg;
        end
    end

endmodule
